@@ design/srec_pkg.sv @@
package srec_pkg;

  localparam int LEN_W     = 6;
  localparam int CHAR_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;

  localparam logic [2:0] ADDR_BYTES_MIN   = 3'd2;
  localparam logic [2:0] ADDR_BYTES_MAX   = 3'd4;
  localparam logic [2:0] ADDR_BYTES_RESET = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_S    = 7'h53;
  localparam logic [CHAR_W-1:0] CHAR_NL   = 7'h0a;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 7'h00;
  localparam logic [CHAR_W-1:0] TERM_DIGIT_BASE = 7'd11;

  typedef struct packed {
    logic             go;
    logic             data_rec;
    logic             term;
    logic [LEN_W-1:0] len;
    logic [31:0]      addr;
  } srec_start_t;

  typedef struct packed {
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] second_char;
    logic              second_valid;
    logic              record_end;
    logic              last_of_run;
  } srec_pair_t;

  function automatic logic [2:0] clamp_size(input logic [2:0] v);
    logic [2:0] r;
    if (v < ADDR_BYTES_MIN) r = ADDR_BYTES_MIN;
    else if (v > ADDR_BYTES_MAX) r = ADDR_BYTES_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] r;
    if (v < 4'd10) r = CHAR_ZERO + {3'b000, v};
    else r = CHAR_A + {3'b000, v} - 7'd10;
    return r;
  endfunction

  // S1/S2/S3 for data, S9/S8/S7 for termination
  function automatic logic [CHAR_W-1:0] type_char(input logic [2:0] size, input logic term);
    logic [CHAR_W-1:0] r;
    if (term) r = CHAR_ZERO + TERM_DIGIT_BASE - {4'b0000, size};
    else r = CHAR_ZERO + {4'b0000, size} - 7'd1;
    return r;
  endfunction

endpackage

@@ design/srec_mem.sv @@
module srec_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/srec_seq.sv @@
module srec_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  srec_pkg::srec_start_t      start,
  input  logic [2:0]                 size,
  input  logic [31:0]                base,
  output logic                       rd_en,
  output logic [srec_pkg::LEN_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  input  logic                       slot_free,
  output logic                       emit,
  output srec_pkg::srec_pair_t       pair,
  output logic                       idle
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HEAD  = 8'b0000_0010,
    S_COUNT = 8'b0000_0100,
    S_ADDR  = 8'b0000_1000,
    S_READ  = 8'b0001_0000,
    S_DATA  = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_NL    = 8'b1000_0000
  } state_t;

  state_t                     state;
  logic                       term_pending;
  logic                       rec_term;
  logic [31:0]                addr;
  logic [srec_pkg::LEN_W-1:0] len;
  logic [srec_pkg::LEN_W-1:0] pos;
  logic [srec_pkg::LEN_W-1:0] pos_inc;
  logic [1:0]                 idx;
  logic [7:0]                 sum;
  logic [7:0]                 sum_next;
  logic [7:0]                 count;
  logic [7:0]                 addr_byte;
  logic [7:0]                 cur_byte;
  logic                       fire;

  assign count   = {5'b00000, size} + {2'b00, len} + 8'd1;
  assign pos_inc = pos + srec_pkg::LEN_W'(1);
  assign rd_en   = (state == S_READ);
  assign rd_addr = pos;
  assign idle    = (state == S_IDLE);

  always_comb begin
    case (idx)
      2'd0:    addr_byte = addr[7:0];
      2'd1:    addr_byte = addr[15:8];
      2'd2:    addr_byte = addr[23:16];
      default: addr_byte = addr[31:24];
    endcase
  end

  // one shared byte path: selects the byte to print and feeds the checksum adder
  always_comb begin
    unique case (state)
      S_COUNT: cur_byte = count;
      S_ADDR:  cur_byte = addr_byte;
      S_DATA:  cur_byte = rd_data;
      S_CHK:   cur_byte = ~sum;
      default: cur_byte = 8'h00;
    endcase
  end

  assign sum_next = sum + cur_byte;

  always_comb begin
    emit = (state == S_HEAD) || (state == S_COUNT) || (state == S_ADDR) ||
           (state == S_DATA) || (state == S_CHK) || (state == S_NL);
    fire = emit && slot_free;
    pair.first_char   = srec_pkg::hex_char(cur_byte[7:4]);
    pair.second_char  = srec_pkg::hex_char(cur_byte[3:0]);
    pair.second_valid = 1'b1;
    pair.record_end   = 1'b0;
    pair.last_of_run  = 1'b0;
    if (state == S_HEAD) begin
      pair.first_char  = srec_pkg::CHAR_S;
      pair.second_char = srec_pkg::type_char(size, rec_term);
    end else if (state == S_NL) begin
      pair.first_char   = srec_pkg::CHAR_NL;
      pair.second_char  = srec_pkg::CHAR_NUL;
      pair.second_valid = 1'b0;
      pair.record_end   = 1'b1;
      pair.last_of_run  = !term_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      term_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start.go) begin
            term_pending <= start.data_rec & start.term;
            rec_term     <= !start.data_rec;
            addr         <= start.data_rec ? start.addr : base;
            len          <= start.data_rec ? start.len : '0;
            state        <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (fire) begin
            sum   <= 8'h00;
            idx   <= size[1:0] - 2'd1;
            pos   <= '0;
            state <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (fire) begin
            sum   <= sum_next;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (fire) begin
            sum <= sum_next;
            if (idx == 2'd0) begin
              state <= (len == '0) ? S_CHK : S_READ;
            end else begin
              idx <= idx - 2'd1;
            end
          end
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (fire) begin
            sum   <= sum_next;
            pos   <= pos_inc;
            state <= (pos_inc == len) ? S_CHK : S_READ;
          end
        end
        S_CHK: begin
          if (fire) begin
            state <= S_NL;
          end
        end
        S_NL: begin
          if (fire) begin
            if (term_pending) begin
              // chain the termination record behind the flushed data record
              term_pending <= 1'b0;
              rec_term     <= 1'b1;
              addr         <= base;
              len          <= '0;
              state        <= S_HEAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    start.go |-> (state == S_IDLE))
    else $error("record start while sequencer busy");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (pos < len))
    else $error("data read past record length");

  a_close_to_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && (state == S_NL) && !term_pending) |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after final newline");

endmodule

@@ design/srecord_stream_encoder_unit.sv @@
// S-record encoder. Data bytes (req_type 0) are buffered until a record of
// BYTES_PER_RECORD bytes is full; that byte then releases the whole record as
// character pairs (S-type, count, address, data, checksum, lone newline).
// End of input (req_type 1) flushes any partial record and appends the
// S9/S8/S7 termination record. A byte that does not fill a record is stored
// in the buffer and starts no output. While a record is sent in_ready is low;
// the sequencer prints the header, count and address pairs, then for each data
// byte reads the buffer and prints it, then the checksum and newline pairs.
// Configuration writes take effect at once and are expected only while no
// record is in flight.
module srecord_stream_encoder_unit #(
  parameter int BYTES_PER_RECORD = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [srec_pkg::CHAR_W-1:0]    first_char,
  output logic [srec_pkg::CHAR_W-1:0]    second_char,
  output logic                           second_valid,
  output logic                           record_end,
  output logic                           last_of_run
);

  localparam int MEM_AW = (BYTES_PER_RECORD > 1) ? $clog2(BYTES_PER_RECORD) : 1;
  localparam logic [srec_pkg::LEN_W-1:0] REC_LEN = srec_pkg::LEN_W'(BYTES_PER_RECORD);

  logic [2:0]                 address_bytes;
  logic [31:0]                base_address;
  logic [srec_pkg::LEN_W-1:0] fill_count;
  logic [31:0]                record_address;
  logic [srec_pkg::LEN_W-1:0] fill_inc;
  logic [2:0]                 size;
  logic                       in_fire;
  logic                       rec_full;
  srec_pkg::srec_start_t      start;
  logic                       seq_idle;
  logic                       emit;
  logic                       slot_free;
  srec_pkg::srec_pair_t       pair;
  logic                       rd_en;
  logic [srec_pkg::LEN_W-1:0] rd_addr;
  logic [7:0]                 rd_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = seq_idle;
  assign in_fire   = in_valid && in_ready;
  assign fill_inc  = fill_count + srec_pkg::LEN_W'(1);
  assign rec_full  = (fill_inc == REC_LEN);
  assign size      = srec_pkg::clamp_size(address_bytes);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    start.go       = in_fire && (req_type || rec_full);
    start.data_rec = req_type ? (fill_count != '0) : 1'b1;
    start.term     = req_type;
    start.len      = req_type ? fill_count : fill_inc;
    start.addr     = record_address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_bytes  <= srec_pkg::ADDR_BYTES_RESET;
      base_address   <= '0;
      record_address <= '0;
      fill_count     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          srec_pkg::CFG_ADDR_BYTES: address_bytes <= cfg_data[2:0];
          srec_pkg::CFG_BASE_ADDRESS: begin
            base_address   <= cfg_data;
            record_address <= cfg_data;
          end
          default: ;
        endcase
      end
      if (in_fire) begin
        if (req_type) begin
          fill_count     <= '0;
          record_address <= base_address;
        end else if (rec_full) begin
          fill_count     <= '0;
          record_address <= record_address + {{(32-srec_pkg::LEN_W){1'b0}}, fill_inc};
        end else begin
          fill_count <= fill_inc;
        end
      end
    end
  end

  srec_mem #(
    .DEPTH (BYTES_PER_RECORD),
    .AW    (MEM_AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_fire && !req_type),
    .wr_addr (fill_count[MEM_AW-1:0]),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[MEM_AW-1:0]),
    .rd_data (rd_data)
  );

  srec_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .size      (size),
    .base      (base_address),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .emit      (emit),
    .pair      (pair),
    .idle      (seq_idle)
  );

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && slot_free) begin
      first_char   <= pair.first_char;
      second_char  <= pair.second_char;
      second_valid <= pair.second_valid;
      record_end   <= pair.record_end;
      last_of_run  <= pair.last_of_run;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < REC_LEN)
    else $error("fill count reached record size");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({first_char, second_char, second_valid, record_end, last_of_run})))
    else $error("output beat changed while stalled");

  a_busy_holds_fill: assert property (@(posedge clk) disable iff (rst)
    !seq_idle |=> $stable(fill_count))
    else $error("fill count moved while a record was in flight");

endmodule

@@ tb/testbench.sv @@
module testbench;

  localparam int RECORD_BYTES   = 32;
  localparam int RANDOM_ITEMS   = 72;
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 100;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 40;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [1:0] {ROW_BYTE, ROW_END, ROW_ADDR_BYTES, ROW_BASE} row_kind_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [srec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic                           req_type;
  logic [7:0]                     data_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [srec_pkg::CHAR_W-1:0]    first_char;
  logic [srec_pkg::CHAR_W-1:0]    second_char;
  logic                           second_valid;
  logic                           record_end;
  logic                           last_of_run;

  srecord_stream_encoder_unit #(.BYTES_PER_RECORD(RECORD_BYTES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_char   (first_char),
    .second_char  (second_char),
    .second_valid (second_valid),
    .record_end   (record_end),
    .last_of_run  (last_of_run)
  );

  // encoder state as the testbench sees it
  logic [7:0]  pending_bytes [RECORD_BYTES];
  int unsigned pending_count;
  logic [31:0] load_address;
  logic [31:0] base_reg;
  logic [2:0]  size_reg;

  srec_pkg::srec_pair_t burst_pairs[$];
  srec_pkg::srec_pair_t expected_pairs[$];

  stim_row_t   stim_rows[$];
  string       stim_text[$];

  int errors;
  int items_sent;
  int pairs_checked;
  int records_checked;
  int full_records;
  int burst_left;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs still expected", cycle_count,
               expected_pairs.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch at pair %0d (cycle %0d): %s", pairs_checked, cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [srec_pkg::CHAR_W-1:0] got,
                             logic [srec_pkg::CHAR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
  endtask

  function automatic logic [srec_pkg::CHAR_W-1:0] hex_ascii(input logic [3:0] n);
    if (n < 4'd10) return srec_pkg::CHAR_ZERO + srec_pkg::CHAR_W'(n);
    return srec_pkg::CHAR_A + srec_pkg::CHAR_W'(n) - 7'd10;
  endfunction

  function automatic int unsigned addr_span();
    if (size_reg < srec_pkg::ADDR_BYTES_MIN) return 32'(srec_pkg::ADDR_BYTES_MIN);
    if (size_reg > srec_pkg::ADDR_BYTES_MAX) return 32'(srec_pkg::ADDR_BYTES_MAX);
    return 32'(size_reg);
  endfunction

  task automatic emit(logic [srec_pkg::CHAR_W-1:0] a, logic [srec_pkg::CHAR_W-1:0] b,
                      logic has_b, logic closes);
    srec_pkg::srec_pair_t p;
    p.first_char   = a;
    p.second_char  = b;
    p.second_valid = has_b;
    p.record_end   = closes;
    p.last_of_run  = 1'b0;
    burst_pairs.push_back(p);
  endtask

  task automatic emit_hex(logic [7:0] b);
    emit(hex_ascii(b[7:4]), hex_ascii(b[3:0]), 1'b1, 1'b0);
  endtask

  task automatic emit_record(logic [srec_pkg::CHAR_W-1:0] type_ch, logic [31:0] addr,
                             int unsigned len);
    int unsigned sz;
    logic [7:0]  sum;
    logic [7:0]  ab;
    sz  = addr_span();
    sum = 8'(sz + len + 1);
    emit(srec_pkg::CHAR_S, type_ch, 1'b1, 1'b0);
    emit_hex(sum);
    for (int i = int'(sz) - 1; i >= 0; i--) begin
      ab  = addr[8*i +: 8];
      sum = sum + ab;
      emit_hex(ab);
    end
    for (int i = 0; i < int'(len); i++) begin
      sum = sum + pending_bytes[i];
      emit_hex(pending_bytes[i]);
    end
    emit_hex(~sum);
    emit(srec_pkg::CHAR_NL, srec_pkg::CHAR_NUL, 1'b0, 1'b1);
  endtask

  // work out the pairs one accepted item releases into burst_pairs
  task automatic predict_encoding(logic req, logic [7:0] b);
    logic [srec_pkg::CHAR_W-1:0] data_type;
    logic [srec_pkg::CHAR_W-1:0] term_type;
    data_type = srec_pkg::CHAR_ZERO + srec_pkg::CHAR_W'(addr_span()) - 7'd1;
    term_type = srec_pkg::CHAR_ZERO + srec_pkg::TERM_DIGIT_BASE
                - srec_pkg::CHAR_W'(addr_span());
    burst_pairs.delete();
    if (req == REQ_DATA) begin
      pending_bytes[pending_count] = b;
      pending_count++;
      if (pending_count == RECORD_BYTES) begin
        emit_record(data_type, load_address, pending_count);
        load_address  = load_address + pending_count;
        pending_count = 0;
        full_records++;
      end
    end else begin
      if (pending_count > 0) emit_record(data_type, load_address, pending_count);
      emit_record(term_type, base_reg, 0);
      pending_count = 0;
      load_address  = base_reg;
    end
  endtask

  // replace the predicted pairs with hand-written record text
  task automatic pairs_from_text(string txt);
    int i;
    burst_pairs.delete();
    i = 0;
    while (i < txt.len()) begin
      if (txt[i] == 8'h0a) begin
        emit(srec_pkg::CHAR_NL, srec_pkg::CHAR_NUL, 1'b0, 1'b1);
        i = i + 1;
      end else begin
        emit(srec_pkg::CHAR_W'(txt[i]), srec_pkg::CHAR_W'(txt[i+1]), 1'b1, 1'b0);
        i = i + 2;
      end
    end
  endtask

  task automatic send_item(logic req, logic [7:0] b, string typed);
    @(negedge clk);
    in_valid  <= 1'b1;
    req_type  <= req;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_encoding(req, b);
    if (typed.len() > 0) pairs_from_text(typed);
    if (burst_pairs.size() > 0) burst_pairs[burst_pairs.size()-1].last_of_run = 1'b1;
    foreach (burst_pairs[i]) expected_pairs.push_back(burst_pairs[i]);
  endtask

  // hold off until every expected pair is out and the encoder has gone quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [srec_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == srec_pkg::CFG_ADDR_BYTES) begin
      size_reg = value[2:0];
    end else if (idx == srec_pkg::CFG_BASE_ADDRESS) begin
      base_reg     = value;
      load_address = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
    end
    burst_left--;
  endtask

  task automatic add_row(row_kind_t kind, logic [31:0] value, string txt);
    stim_row_t r;
    r.kind  = kind;
    r.value = value;
    stim_rows.push_back(r);
    stim_text.push_back(txt);
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
      2:       return 32'h0000_FFE0 + $urandom_range(0, 31);
      3:       return 32'h00FF_FFE0 + $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // receiver: stall pattern switches to a randomly chosen mode after each random span
  initial begin
    ready_mode_t mode;
    int          span;
    int          tick;
    out_ready = 1'b0;
    tick = 0;
    forever begin
      mode = ready_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RDY_ALWAYS:   out_ready <= 1'b1;
          RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
          RDY_PERIODIC: out_ready <= ((tick % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    srec_pkg::srec_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair 0x%02h 0x%02h", first_char, second_char));
      end else begin
        want = expected_pairs.pop_front();
        check_field("first_char", first_char, want.first_char);
        check_field("second_char", second_char, want.second_char);
        check_field("second_valid", srec_pkg::CHAR_W'(second_valid),
                    srec_pkg::CHAR_W'(want.second_valid));
        check_field("record_end", srec_pkg::CHAR_W'(record_end),
                    srec_pkg::CHAR_W'(want.record_end));
        check_field("last_of_run", srec_pkg::CHAR_W'(last_of_run),
                    srec_pkg::CHAR_W'(want.last_of_run));
        if (want.record_end) records_checked++;
      end
      pairs_checked++;
    end
  end

  initial begin
    int          random_items;
    int          nbytes;
    int          sel;
    logic [31:0] v;

    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= srec_pkg::CFG_ADDR_BYTES;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    req_type  <= REQ_DATA;
    data_byte <= '0;
    errors = 0;
    items_sent = 0;
    pairs_checked = 0;
    records_checked = 0;
    full_records = 0;
    burst_left = 0;
    cycle_count = 0;
    pending_count = 0;
    size_reg = srec_pkg::ADDR_BYTES_RESET;
    base_reg = '0;
    load_address = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    add_row(ROW_END,        0,            "S70500000000FA\n");
    add_row(ROW_ADDR_BYTES, 2,            "");
    add_row(ROW_END,        0,            "S9030000FC\n");
    add_row(ROW_ADDR_BYTES, 3,            "");
    add_row(ROW_END,        0,            "S804000000FB\n");
    add_row(ROW_BASE,       32'hFFFFFFFF, "");
    add_row(ROW_ADDR_BYTES, 4,            "");
    add_row(ROW_END,        0,            "S705FFFFFFFFFE\n");
    // below-range size acts as two bytes
    add_row(ROW_ADDR_BYTES, 0,            "");
    add_row(ROW_BYTE,       8'h00,        "");
    add_row(ROW_END,        0,            "S104FFFF00FD\nS903FFFFFE\n");
    // above-range size acts as four bytes
    add_row(ROW_ADDR_BYTES, 7,            "");
    add_row(ROW_BASE,       0,            "");
    add_row(ROW_BYTE,       8'hFF,        "");
    add_row(ROW_END,        0,            "S30600000000FFFA\nS70500000000FA\n");
    add_row(ROW_ADDR_BYTES, 1,            "");
    add_row(ROW_BYTE,       8'h5A,        "");
    add_row(ROW_BYTE,       8'hA5,        "");
    // rebase and resize while bytes are pending
    add_row(ROW_BASE,       32'h12345678, "");
    add_row(ROW_BYTE,       8'h3C,        "");
    add_row(ROW_ADDR_BYTES, 5,            "");
    add_row(ROW_END,        0,            "");
    add_row(ROW_ADDR_BYTES, 32'hFFFFFFFB, "");
    add_row(ROW_BASE,       32'h00FFFFFF, "");
    add_row(ROW_BYTE,       8'h81,        "");
    add_row(ROW_BYTE,       8'h7E,        "");
    add_row(ROW_END,        0,            "");
    // one full record released by its last byte
    for (int k = 0; k < RECORD_BYTES; k++) add_row(ROW_BYTE, 32'(k * 7 + 1), "");

    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_BYTE: send_item(REQ_DATA, stim_rows[i].value[7:0], stim_text[i]);
        ROW_END:  send_item(REQ_END, 8'h00, stim_text[i]);
        ROW_ADDR_BYTES: begin
          wait_idle();
          write_reg(srec_pkg::CFG_ADDR_BYTES, stim_rows[i].value);
        end
        ROW_BASE: begin
          wait_idle();
          write_reg(srec_pkg::CFG_BASE_ADDRESS, stim_rows[i].value);
        end
      endcase
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 2) != 0) begin
        v = $urandom;
        if ($urandom_range(0, 3) != 0) v = $urandom_range(2, 4);
        else v[2:0] = 3'($urandom_range(0, 7));
        write_reg(srec_pkg::CFG_ADDR_BYTES, v);
      end
      if ($urandom_range(0, 2) != 0) write_reg(srec_pkg::CFG_BASE_ADDRESS, pick_base());

      sel = $urandom_range(0, 9);
      if (sel < 4) nbytes = $urandom_range(0, 10);
      else if (sel < 8) nbytes = $urandom_range(25, 40);
      else nbytes = $urandom_range(60, 70);
      if (nbytes > RANDOM_ITEMS - random_items) nbytes = RANDOM_ITEMS - random_items;

      repeat (nbytes) begin
        pace();
        if ($urandom_range(0, 24) == 0) wait_idle();
        send_item(REQ_DATA, 8'($urandom), "");
        random_items++;
      end
      // now and then leave a partial record pending into the next phase
      if ($urandom_range(0, 4) != 0) begin
        pace();
        send_item(REQ_END, 8'($urandom), "");
        random_items++;
      end
    end

    send_item(REQ_END, 8'h00, "");
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);

    if (expected_pairs.size() != 0)
      report_mismatch($sformatf("%0d expected pairs never arrived", expected_pairs.size()));

    $display("run covered %0d input items, %0d records (%0d full) in %0d character pairs",
             items_sent, records_checked, full_records, pairs_checked);
    $display("mismatches: %0d, cycles: %0d", errors, cycle_count);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
